### hdl/csvtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csvtok_pkg;

   // Parser modes
   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_PLAIN  = 3'd1,
      MODE_QUOTED = 3'd2,
      MODE_QSEEN  = 3'd3,
      MODE_DROP   = 3'd4
   } mode_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int unsigned CAP_W     = 13;
   localparam logic [12:0] CAP_RESET = 13'd512;

   // One result transaction
   typedef struct packed {
      logic [7:0] cell_byte;
      logic       has_byte;
      logic       cell_done;
      logic       row_done;
      logic       row_error;
   } result_type;

endpackage
`default_nettype wire

### hdl/csv_cell_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// CSV cell tokenizer.
// Input stream (req_*): one byte of CSV text per transaction. Bytes 0, 10 and
// 13 end a row, a comma ends a cell, quoted cells fold a doubled quote.
// Result stream (rsp_*): at most one transaction per input byte. rsp_tdata
// carries the decoded character; rsp_tuser flags has_byte, cell_done and
// row_error; rsp_tlast marks a cleanly finished row. Opening and closing
// quotes and bytes of a dropped row produce no result.
// Config (csr_*): write the cell buffer size; always ready. Write only while
// the block is idle. Values above MAX_CAPACITY saturate.
// Path: the input register loads at req acceptance, then parse logic fills
// the result register, which drives rsp_tvalid. Throughput: one byte per
// cycle while no result is held stalled by rsp_tready. Reset: synchronous,
// active high; empties both registers, returns the parser to cell start and
// the buffer size to 512.
// Stall: while rsp_tready is low with a result held, the input register
// holds its byte and req_tready falls once it is occupied.
module csv_cell_tokenizer #(
   parameter int unsigned MAX_CAPACITY = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // text_byte[7:0]
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cell_byte[7:0]
   output logic      [7:0]  rsp_tdata,
   // has_byte[0], cell_done[1], row_error[2]
   output logic      [2:0]  rsp_tuser,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [12:0] csr_data,
   input  wire logic        csr_valid,
   output logic             csr_ready
);

   // Count never exceeds capacity - 1, so it fits in the capacity width
   localparam int unsigned CntW  = $clog2(MAX_CAPACITY + 1);
   localparam int unsigned WideW = (CntW > csvtok_pkg::CAP_W) ? CntW : csvtok_pkg::CAP_W;

   logic [WideW-1:0]        eff_cap;

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    advance;

   csvtok_pkg::mode_type    mode_ff;
   csvtok_pkg::mode_type    mode_in;
   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;
   logic                    emit;
   csvtok_pkg::result_type  result;

   logic                    rsp_valid_ff;
   csvtok_pkg::result_type  rsp_ff;

   assign csr_ready = 1'b1;

   csvtok_cap_reg #(
      .MAX_CAPACITY (MAX_CAPACITY),
      .WIDE_W       (WideW)
   ) u_cap (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid),
      .wr_data (csr_data),
      .eff_cap (eff_cap)
   );

   // Parse the held byte when a result slot is free (or being freed)
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   csvtok_parse #(
      .CNT_W  (CntW),
      .WIDE_W (WideW)
   ) u_parse (
      .mode       (mode_ff),
      .count      (count_ff),
      .text_byte  (in_byte_ff),
      .eff_cap    (eff_cap),
      .mode_next  (mode_in),
      .count_next (count_in),
      .emit       (emit),
      .result     (result)
   );

   // Advance parser state once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= csvtok_pkg::MODE_START;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Result register: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.cell_byte;
   assign rsp_tuser  = {rsp_ff.row_error, rsp_ff.cell_done, rsp_ff.has_byte};
   assign rsp_tlast  = rsp_ff.row_done;

`ifndef ASSERT_OFF
   // A held result is never overwritten by a new one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(advance && emit))
      else $error("result overwritten while stalled");

   // An error result carries no other marks
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> !rsp_tlast && rsp_tuser[1:0] == 2'b00)
      else $error("row error mixed with other marks");

   // Outside a cell the character count is clear
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == csvtok_pkg::MODE_START || mode_ff == csvtok_pkg::MODE_DROP
      |-> count_ff == '0)
      else $error("count not cleared outside a cell");

   // A character result always follows a counted character
   assert property (@(posedge clock) disable iff (reset)
      advance && emit && result.has_byte |=> count_ff != '0)
      else $error("character emitted without count");
`endif

endmodule
`default_nettype wire

### hdl/csvtok_cap_reg.sv
`timescale 1ns / 1ps
`default_nettype none
module csvtok_cap_reg #(
   parameter int unsigned MAX_CAPACITY = 4096,
   parameter int unsigned WIDE_W       = 13
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [csvtok_pkg::CAP_W-1:0] wr_data,
   output logic      [WIDE_W-1:0]          eff_cap
);

   localparam logic [WIDE_W-1:0] MaxCap = WIDE_W'(MAX_CAPACITY);

   logic [csvtok_pkg::CAP_W-1:0] cap_ff;
   logic [WIDE_W-1:0]            cap_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= csvtok_pkg::CAP_RESET;
      end else if (wr_en) begin
         cap_ff <= wr_data;
      end
   end

   // Saturate to the largest supported buffer
   assign cap_wide = WIDE_W'(cap_ff);
   assign eff_cap  = (cap_wide > MaxCap) ? MaxCap : cap_wide;

endmodule
`default_nettype wire

### hdl/csvtok_parse.sv
`timescale 1ns / 1ps
`default_nettype none
module csvtok_parse #(
   parameter int unsigned CNT_W  = 13,
   parameter int unsigned WIDE_W = 13
) (
   input  wire csvtok_pkg::mode_type   mode,
   input  wire logic [CNT_W-1:0]       count,
   input  wire logic [7:0]             text_byte,
   input  wire logic [WIDE_W-1:0]      eff_cap,
   output csvtok_pkg::mode_type        mode_next,
   output logic      [CNT_W-1:0]       count_next,
   output logic                        emit,
   output csvtok_pkg::result_type      result
);

   logic             row_end;
   logic             is_quote;
   logic             is_comma;
   logic             full;
   logic [WIDE_W:0]  count_plus;

   assign row_end  = text_byte inside {csvtok_pkg::CH_NUL, csvtok_pkg::CH_LF,
                                       csvtok_pkg::CH_CR};
   assign is_quote = (text_byte == csvtok_pkg::CH_QUOTE);
   assign is_comma = (text_byte == csvtok_pkg::CH_COMMA);

   // Adding one more character would reach capacity
   assign count_plus = (WIDE_W + 1)'(count) + (WIDE_W + 1)'(1);
   assign full       = count_plus >= {1'b0, eff_cap};

   always_comb begin
      mode_next  = mode;
      count_next = count;
      emit       = 1'b0;
      result     = '0;
      case (mode)
         csvtok_pkg::MODE_PLAIN: begin
            emit = 1'b1;
            if (row_end || is_comma) begin
               mode_next        = csvtok_pkg::MODE_START;
               count_next       = '0;
               result.cell_done = 1'b1;
               result.row_done  = row_end;
            end else if (is_quote || full) begin
               mode_next        = csvtok_pkg::MODE_DROP;
               count_next       = '0;
               result.row_error = 1'b1;
            end else begin
               count_next       = count + CNT_W'(1);
               result.cell_byte = text_byte;
               result.has_byte  = 1'b1;
            end
         end
         csvtok_pkg::MODE_QUOTED: begin
            if (is_quote) begin
               mode_next = csvtok_pkg::MODE_QSEEN;
            end else begin
               emit = 1'b1;
               if (row_end) begin
                  // Line break closes the row; nothing left to drop
                  mode_next        = csvtok_pkg::MODE_START;
                  count_next       = '0;
                  result.row_error = 1'b1;
               end else if (full) begin
                  mode_next        = csvtok_pkg::MODE_DROP;
                  count_next       = '0;
                  result.row_error = 1'b1;
               end else begin
                  count_next       = count + CNT_W'(1);
                  result.cell_byte = text_byte;
                  result.has_byte  = 1'b1;
               end
            end
         end
         csvtok_pkg::MODE_QSEEN: begin
            emit = 1'b1;
            if (is_quote && !full) begin
               mode_next        = csvtok_pkg::MODE_QUOTED;
               count_next       = count + CNT_W'(1);
               result.cell_byte = csvtok_pkg::CH_QUOTE;
               result.has_byte  = 1'b1;
            end else if (row_end || is_comma) begin
               mode_next        = csvtok_pkg::MODE_START;
               count_next       = '0;
               result.cell_done = 1'b1;
               result.row_done  = row_end;
            end else begin
               mode_next        = csvtok_pkg::MODE_DROP;
               count_next       = '0;
               result.row_error = 1'b1;
            end
         end
         csvtok_pkg::MODE_DROP: begin
            if (row_end) begin
               mode_next  = csvtok_pkg::MODE_START;
               count_next = '0;
            end
         end
         default: begin
            count_next = '0;
            if (row_end) begin
               mode_next       = csvtok_pkg::MODE_START;
               emit            = 1'b1;
               result.row_done = 1'b1;
            end else if (is_quote) begin
               mode_next = csvtok_pkg::MODE_QUOTED;
            end else if (is_comma) begin
               mode_next        = csvtok_pkg::MODE_START;
               emit             = 1'b1;
               result.cell_done = 1'b1;
            end else if (full) begin
               mode_next        = csvtok_pkg::MODE_DROP;
               emit             = 1'b1;
               result.row_error = 1'b1;
            end else begin
               mode_next        = csvtok_pkg::MODE_PLAIN;
               count_next       = CNT_W'(1);
               emit             = 1'b1;
               result.cell_byte = text_byte;
               result.has_byte  = 1'b1;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

### tb/csv_cell_tokenizer_test.sv
`timescale 1ns / 1ps
module csv_cell_tokenizer_test;

   localparam int MAX_CAP        = 4096;
   localparam int HOLD_CYCLES    = 64;    // long receiver hold-off
   localparam int SETTLE_CYCLES  = 6;     // covers the input and result registers, with margin
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int DRAIN_LIMIT    = 2000;
   localparam int PHASE_BYTES    = 32;

   logic        clock;
   logic        reset      = 1'b1;
   logic [7:0]  req_tdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;   // cell_byte[7:0]
   logic [2:0]  rsp_tuser;   // has_byte[0], cell_done[1], row_error[2]
   logic        rsp_tlast;   // row_done
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [12:0] csr_data   = '0;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;

   // Text bytes waiting for the driver, and the tokens they must produce.
   logic [7:0]             pending_bytes[$];
   csvtok_pkg::result_type expected_tokens[$];

   // Shadow copy of the tokenizer state.
   logic [12:0]          shadow_capacity;
   csvtok_pkg::mode_type shadow_mode;
   int                   shadow_count;

   int  mismatch_count = 0;
   int  idle_cycles;
   int  send_gap;
   int  rx_wait;
   int  rx_draw;
   int  hold_left;
   int  holds_served;
   int  hold_asked = 0;
   bit  no_idle    = 1'b0;

   csv_cell_tokenizer #(
      .MAX_CAPACITY(MAX_CAP)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_data  (csr_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Tokenizer prediction
   // ---------------------------------------------------------------------

   // Append a character unless the cell would reach the buffer limit.
   function automatic bit emit_char(input logic [7:0] ch,
                                    input csvtok_pkg::mode_type next_mode,
                                    output csvtok_pkg::result_type r);
      int cap;
      cap = (shadow_capacity > MAX_CAP) ? MAX_CAP : int'(shadow_capacity);
      r = '0;
      if (shadow_count + 1 >= cap) begin
         shadow_mode  = csvtok_pkg::MODE_DROP;
         shadow_count = 0;
         r.row_error  = 1'b1;
      end else begin
         shadow_count++;
         shadow_mode = next_mode;
         r.cell_byte = ch;
         r.has_byte  = 1'b1;
      end
      return 1'b1;
   endfunction

   // Flag a malformed row; a row end byte closes it, anything else starts a drop.
   function automatic bit flag_error(input bit at_row_end,
                                     output csvtok_pkg::result_type r);
      shadow_mode  = at_row_end ? csvtok_pkg::MODE_START : csvtok_pkg::MODE_DROP;
      shadow_count = 0;
      r = '0;
      r.row_error = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit close_cell(input bit row_end, output csvtok_pkg::result_type r);
      shadow_mode  = csvtok_pkg::MODE_START;
      shadow_count = 0;
      r = '0;
      r.cell_done = 1'b1;
      r.row_done  = row_end;
      return 1'b1;
   endfunction

   // Advance the shadow state by one text byte; return 1 if a token results.
   function automatic bit tokenize_byte(input logic [7:0] b,
                                        output csvtok_pkg::result_type r);
      bit row_end;
      row_end = b inside {csvtok_pkg::CH_NUL, csvtok_pkg::CH_LF, csvtok_pkg::CH_CR};
      r = '0;
      case (shadow_mode)
         csvtok_pkg::MODE_PLAIN: begin
            if (row_end) return close_cell(1'b1, r);
            if (b == csvtok_pkg::CH_COMMA) return close_cell(1'b0, r);
            if (b == csvtok_pkg::CH_QUOTE) return flag_error(1'b0, r);
            return emit_char(b, csvtok_pkg::MODE_PLAIN, r);
         end
         csvtok_pkg::MODE_QUOTED: begin
            if (b == csvtok_pkg::CH_QUOTE) begin
               shadow_mode = csvtok_pkg::MODE_QSEEN;
               return 1'b0;
            end
            if (row_end) return flag_error(1'b1, r);
            return emit_char(b, csvtok_pkg::MODE_QUOTED, r);
         end
         csvtok_pkg::MODE_QSEEN: begin
            // doubled quote folds into one quote character
            if (b == csvtok_pkg::CH_QUOTE)
               return emit_char(csvtok_pkg::CH_QUOTE, csvtok_pkg::MODE_QUOTED, r);
            if (b == csvtok_pkg::CH_COMMA) return close_cell(1'b0, r);
            if (row_end) return close_cell(1'b1, r);
            return flag_error(1'b0, r);
         end
         csvtok_pkg::MODE_DROP: begin
            if (row_end) begin
               shadow_mode  = csvtok_pkg::MODE_START;
               shadow_count = 0;
            end
            return 1'b0;
         end
         default: begin
            shadow_count = 0;
            if (row_end) begin
               // row end at cell start: no cell, just the row mark
               shadow_mode = csvtok_pkg::MODE_START;
               r.row_done  = 1'b1;
               return 1'b1;
            end
            if (b == csvtok_pkg::CH_QUOTE) begin
               shadow_mode = csvtok_pkg::MODE_QUOTED;
               return 1'b0;
            end
            if (b == csvtok_pkg::CH_COMMA) return close_cell(1'b0, r);
            return emit_char(b, csvtok_pkg::MODE_PLAIN, r);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   // Random byte that is plain cell content (no quote, comma or row end).
   function automatic logic [7:0] text_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b inside {csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_LF,
                       csvtok_pkg::CH_CR, csvtok_pkg::CH_NUL});
      return b;
   endfunction

   function automatic logic [7:0] row_end_byte();
      case ($urandom_range(0, 2))
         0:       return csvtok_pkg::CH_LF;
         1:       return csvtok_pkg::CH_CR;
         default: return csvtok_pkg::CH_NUL;
      endcase
   endfunction

   // Queue one row: mostly well-formed cells, with some broken ones and noise.
   function automatic void queue_random_row(input int cap);
      int cells;
      int len;
      int kind;
      cells = $urandom_range(0, 4);
      for (int c = 0; c < cells; c++) begin
         if (c > 0) pending_bytes.push_back(csvtok_pkg::CH_COMMA);
         // lengths near the buffer limit where the limit is small
         if (cap <= 48 && $urandom_range(0, 3) == 0)
            len = $urandom_range(cap + 1, (cap > 2) ? cap - 2 : 0);
         else
            len = $urandom_range(0, 8);
         kind = $urandom_range(0, 19);
         if (kind < 9) begin
            for (int i = 0; i < len; i++) pending_bytes.push_back(text_char());
         end else if (kind < 16) begin
            pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 5))
                  0: begin
                     pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
                     pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
                  end
                  1:       pending_bytes.push_back(csvtok_pkg::CH_COMMA);
                  default: pending_bytes.push_back(text_char());
               endcase
            end
            pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
         end else if (kind == 16) begin
            // quote inside an unquoted cell
            for (int i = 0; i < len; i++) pending_bytes.push_back(text_char());
            pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
            for (int i = 0; i < 3; i++) pending_bytes.push_back(text_char());
         end else if (kind == 17) begin
            // stray character after the closing quote
            pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++) pending_bytes.push_back(text_char());
            pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
            pending_bytes.push_back(text_char());
            pending_bytes.push_back(csvtok_pkg::CH_COMMA);
         end else if (kind == 18) begin
            // row end inside quotes closes the row itself
            pending_bytes.push_back(csvtok_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++) pending_bytes.push_back(text_char());
            pending_bytes.push_back(row_end_byte());
            return;
         end else begin
            for (int i = 0; i < $urandom_range(1, 6); i++)
               pending_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         pending_bytes.push_back(csvtok_pkg::CH_CR);
         pending_bytes.push_back(csvtok_pkg::CH_LF);
      end else
         pending_bytes.push_back(row_end_byte());
   endfunction

   // Write the buffer size; the caller makes sure the block is idle.
   task automatic write_capacity(input logic [12:0] value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Hold off until every byte is sent and every token has come back.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic log_mismatch(input string what, input csvtok_pkg::result_type want);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("%s: expected byte %02h has %b cell %b row %b err %b", what,
                want.cell_byte, want.has_byte, want.cell_done, want.row_done,
                want.row_error);
         $display(", got byte %02h has %b cell %b row %b err %b",
                  rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast, rsp_tuser[2]);
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: one text byte per transaction, random gap after each
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_tdata  <= pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            send_gap   <= no_idle ? 0 : $urandom_range(0, 3);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall after each token, long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         hold_left    <= 0;
         holds_served <= 0;
         rx_wait      <= 0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (holds_served != hold_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait    <= rx_wait - 1;
         rsp_tready <= (rx_wait == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         rx_draw = no_idle ? 0 : $urandom_range(0, 3);
         rx_wait    <= rx_draw;
         rsp_tready <= (rx_draw == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted byte, check each accepted token
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      csvtok_pkg::result_type want;
      if (reset) begin
         shadow_capacity = csvtok_pkg::CAP_RESET;
         shadow_mode     = csvtok_pkg::MODE_START;
         shadow_count    = 0;
         idle_cycles     <= 0;
      end else begin
         if (csr_valid && csr_ready) shadow_capacity = csr_data;
         if (req_tvalid && req_tready) begin
            if (tokenize_byte(req_tdata, want)) expected_tokens.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               log_mismatch("unexpected token", '0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tdata !== want.cell_byte || rsp_tuser[0] !== want.has_byte ||
                   rsp_tuser[1] !== want.cell_done || rsp_tlast !== want.row_done ||
                   rsp_tuser[2] !== want.row_error)
                  log_mismatch("token mismatch", want);
            end
         end
         // Watchdog: advance only while no transaction moves on any channel.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("csv_cell_tokenizer_test: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      // Hand-picked rows at the reset buffer size: extreme bytes, a doubled
      // quote, empty row, empty cells, quote in a plain cell, a stray byte
      // after a closing quote, and a row end inside quotes.
      logic [7:0] opening[$] = '{8'hFF, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE, "a",
                                 csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_QUOTE, 8'h01,
                                 csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_LF,
                                 csvtok_pkg::CH_CR,
                                 csvtok_pkg::CH_COMMA, csvtok_pkg::CH_NUL,
                                 "x", csvtok_pkg::CH_QUOTE, "y", csvtok_pkg::CH_LF,
                                 csvtok_pkg::CH_QUOTE, "a", csvtok_pkg::CH_QUOTE, "b",
                                 csvtok_pkg::CH_COMMA, csvtok_pkg::CH_LF,
                                 csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR,
                                 "b", csvtok_pkg::CH_CR};
      logic [12:0] phase_caps[$] = '{13'd1, 13'd0, 13'd2, 13'd3, 13'd6, 13'd13,
                                     13'd40, 13'd4096, 13'd8191, 13'd512, 13'd29};
      int cap;
      int added;
      int before_size;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) pending_bytes.push_back(opening[i]);
      wait_idle();

      phase_caps.push_back(13'($urandom_range(1, 64)));
      phase_caps.push_back(13'($urandom_range(1, 64)));
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         cap = (phase_caps[p] == 0) ? 1 :
               (phase_caps[p] > MAX_CAP) ? MAX_CAP : int'(phase_caps[p]);
         no_idle = (p == 5);
         // receiver stalls long while the sender keeps pushing bytes
         if (p == 3) hold_asked++;
         added = 0;
         while (added < PHASE_BYTES) begin
            before_size = pending_bytes.size();
            queue_random_row(cap);
            added += pending_bytes.size() - before_size;
         end
         wait_idle();
      end
      no_idle = 1'b0;

      // Saturated limit: a buffer size just above the largest acts as the
      // largest, under one more long receiver hold-off.
      write_capacity(13'd4097);
      hold_asked++;
      for (int r = 0; r < 4; r++) queue_random_row(MAX_CAP);

      // Drain: every byte out, every token back, then let the pipe settle.
      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
      for (int i = 0; i < DRAIN_LIMIT && expected_tokens.size() != 0; i++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         mismatch_count += expected_tokens.size();
         $display("%0d expected tokens never arrived", expected_tokens.size());
      end

      if (mismatch_count == 0)
         $display("csv_cell_tokenizer_test: PASS");
      else
         $display("csv_cell_tokenizer_test: FAIL");
      $finish;
   end

endmodule
